[hw/rtl/iarca_pkg.sv]
// Shared field widths, default sizes and command and register codes for the ADC ring averager.
package iarca_pkg;

  // Fixed field widths of the input, output and configuration beats.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CHANNEL_W  = 4;
  localparam int unsigned NEWEST_W   = 10;
  localparam int unsigned CH_CFG_W   = 5;
  localparam int unsigned LEN_CFG_W  = 11;
  localparam int unsigned WIN_CFG_W  = 9;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default sizes of the block.
  localparam int unsigned RING_DEPTH_DEF   = 1024;
  localparam int unsigned MAX_CHANNELS_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF   = 256;

  // Register values after reset, before clamping to the sizes above.
  localparam int unsigned CH_RST  = 1;
  localparam int unsigned LEN_RST = 1024;
  localparam int unsigned WIN_RST = 16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_RING_LENGTH   = 2'd1,
    REG_WINDOW_LENGTH = 2'd2
  } reg_idx_e;

endpackage

[hw/rtl/iarca_if.sv]
// Handshake interfaces for the input, result and configuration channels of the ADC ring averager.
interface iarca_in_if import iarca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SAMPLE_W-1:0]  sample;
  logic [CHANNEL_W-1:0] channel;
  logic [NEWEST_W-1:0]  newest_index;

  modport source (output valid, output command, output sample, output channel,
                  output newest_index, input ready);
  modport sink   (input valid, input command, input sample, input channel,
                  input newest_index, output ready);
endinterface

interface iarca_out_if import iarca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  average;
  logic [CHANNEL_W-1:0] channel_echo;

  modport source (output valid, output average, output channel_echo, input ready);
  modport sink   (input valid, input average, input channel_echo, output ready);
endinterface

interface iarca_cfg_if import iarca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/iarca_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module iarca_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/iarca_div.sv]
// Radix-2 restoring divider that yields one quotient bit per cycle.
module iarca_div #(
  parameter int unsigned DW = 21,
  parameter int unsigned VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   div_q, div_d;
  logic [VW:0]     trial;
  logic [VW:0]     diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder always stays below the divisor, so the difference fits VW bits.
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

[hw/rtl/interleaved_adc_ring_channel_average_unit.sv]
// Top level of the interleaved ADC ring buffer with per-channel moving average.
//
// Sample writes go straight into a ring RAM at a wrapping write pointer and are taken one
// beat per cycle, back to back, whenever no query is at work. A query beat names a channel
// and the ring index of the newest sample; the block works out the channel's latest slot at
// or before that index, walks back by the channel count over window_length entries, sums
// them and returns the truncated mean with the channel echoed. A query holds the input
// channel until its mean is in the output register. DW, the dividend width of the shared
// radix-2 divider, is 21 bits at the default sizes. Five index remainders and
// the final mean all go through that one divider, one quotient bit per cycle, and the walk
// reads the single RAM read port once per cycle. The finished mean sits in an output
// register, so further sample writes are taken while it waits to be collected. Registers
// are clamped when written: a value of zero acts as one and a value above the built-in
// size saturates. The ring RAM is not cleared by reset; every entry a query reads must
// have been written before.
module interleaved_adc_ring_channel_average_unit import iarca_pkg::*; #(
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  iarca_cfg_if.sink cfg_i,
  iarca_in_if.sink  in_i,
  iarca_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(RING_DEPTH);
  localparam int unsigned LenW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned ChW   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned WinW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW  = SAMPLE_W + WinW;
  localparam int unsigned PosW  = $clog2(RING_DEPTH + MAX_CHANNELS);

  localparam int unsigned DwA = (SumW > PosW) ? SumW : PosW;
  localparam int unsigned DwB = (DwA > NEWEST_W) ? DwA : NEWEST_W;
  localparam int unsigned DwC = (DwB > LenW) ? DwB : LenW;
  localparam int unsigned DW  = (DwC > ChW) ? DwC : ChW;
  localparam int unsigned VwA = (LenW > ChW) ? LenW : ChW;
  localparam int unsigned VW  = (VwA > WinW) ? VwA : WinW;

  localparam int unsigned ChRstC  = (CH_RST > MAX_CHANNELS) ? MAX_CHANNELS : CH_RST;
  localparam int unsigned LenRstC = (LEN_RST > RING_DEPTH) ? RING_DEPTH : LEN_RST;
  localparam int unsigned WinRstC = (WIN_RST > MAX_WINDOW) ? MAX_WINDOW : WIN_RST;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NMOD,   // newest index modulo ring length
    S_NCH,    // reduced index modulo channel count
    S_CCH,    // channel modulo channel count
    S_STEP,   // channel count modulo ring length
    S_PMOD,   // start slot modulo ring length
    S_WALK,
    S_DRAIN,
    S_AVG,
    S_DONE
  } state_e;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) begin
      return 1;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // One slot back by the channel count, wrapping at the ring length.
  function automatic logic [LenW-1:0] step_back(logic [LenW-1:0] p, logic [LenW-1:0] stp,
                                                logic [LenW-1:0] len);
    if (p >= stp) begin
      return p - stp;
    end
    return p + (len - stp);
  endfunction

  // Configuration, stored already clamped.
  logic [ChW-1:0]  ch_q;
  logic [LenW-1:0] len_q;
  logic [WinW-1:0] win_q;

  // Control state.
  state_e          state_q, state_d;
  logic            div_start_q, div_start_d;
  logic            rd_vld_q, rd_vld_d;
  logic [WinW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic            out_valid_q, out_valid_d;

  // Query payload.
  logic [CHANNEL_W-1:0] chan_q, chan_d;
  logic [NEWEST_W-1:0]  newest_q, newest_d;
  logic [LenW-1:0]      nm_q, nm_d;
  logic [ChW-1:0]       r1_q, r1_d;
  logic [ChW-1:0]       r2_q, r2_d;
  logic [LenW-1:0]      step_q, step_d;
  logic [LenW-1:0]      pos_q, pos_d;
  logic [SumW-1:0]      sum_q, sum_d;
  logic [SAMPLE_W-1:0]  res_q, res_d;
  logic [SAMPLE_W-1:0]  out_avg_q, out_avg_d;
  logic [CHANNEL_W-1:0] out_chan_q, out_chan_d;

  // Datapath wires.
  logic [PosW-1:0]     pos_full;
  logic [LenW-1:0]     wp_eff;
  logic [LenW-1:0]     wp_nxt;
  logic                mem_we;
  logic [SAMPLE_W-1:0] rdata;
  logic [DW-1:0]       div_dividend;
  logic [VW-1:0]       div_divisor;
  logic                div_done;
  logic [DW-1:0]       div_quot;
  logic [VW-1:0]       div_rem;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= ChW'(ChRstC);
      len_q <= LenW'(LenRstC);
      win_q <= WinW'(WinRstC);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CHANNEL_COUNT: begin
          ch_q <= ChW'(clamp_reg(32'(cfg_i.data[CH_CFG_W-1:0]), MAX_CHANNELS));
        end
        REG_RING_LENGTH: begin
          len_q <= LenW'(clamp_reg(32'(cfg_i.data[LEN_CFG_W-1:0]), RING_DEPTH));
        end
        REG_WINDOW_LENGTH: begin
          win_q <= WinW'(clamp_reg(32'(cfg_i.data[WIN_CFG_W-1:0]), MAX_WINDOW));
        end
        default: begin
        end
      endcase
    end
  end

  // The channel's latest slot is the index rounded down to a channel period plus the
  // channel's own position; it can land past the index, and then one period is undone.
  assign pos_full = PosW'(nm_q) - PosW'(r1_q) + PosW'(r2_q);

  // A pointer left beyond a shortened ring restarts at slot zero.
  assign wp_eff = (LenW'(wp_q) >= len_q) ? '0 : LenW'(wp_q);
  assign wp_nxt = wp_eff + LenW'(1);

  always_comb begin
    case (state_q)
      S_NMOD:  begin
        div_dividend = DW'(newest_q);
        div_divisor  = VW'(len_q);
      end
      S_NCH:   begin
        div_dividend = DW'(nm_q);
        div_divisor  = VW'(ch_q);
      end
      S_CCH:   begin
        div_dividend = DW'(chan_q);
        div_divisor  = VW'(ch_q);
      end
      S_STEP:  begin
        div_dividend = DW'(ch_q);
        div_divisor  = VW'(len_q);
      end
      S_PMOD:  begin
        div_dividend = DW'(pos_full);
        div_divisor  = VW'(len_q);
      end
      S_AVG:   begin
        div_dividend = DW'(sum_q);
        div_divisor  = VW'(win_q);
      end
      default: begin
        div_dividend = DW'(sum_q);
        div_divisor  = VW'(win_q);
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    rd_vld_d    = 1'b0;
    cnt_d       = cnt_q;
    wp_d        = wp_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    chan_d      = chan_q;
    newest_d    = newest_q;
    nm_d        = nm_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    step_d      = step_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    res_d       = res_q;
    out_avg_d   = out_avg_q;
    out_chan_d  = out_chan_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Read data arrives in the cycle after its address.
    if (rd_vld_q) begin
      sum_d = sum_q + SumW'(rdata);
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.command == CMD_WRITE) begin
            mem_we = 1'b1;
            wp_d   = (wp_nxt >= len_q) ? '0 : wp_nxt[AddrW-1:0];
          end else begin
            chan_d      = in_i.channel;
            newest_d    = in_i.newest_index;
            state_d     = S_NMOD;
            div_start_d = 1'b1;
          end
        end
      end
      S_NMOD: begin
        if (div_done) begin
          nm_d        = div_rem[LenW-1:0];
          state_d     = S_NCH;
          div_start_d = 1'b1;
        end
      end
      S_NCH: begin
        if (div_done) begin
          r1_d        = div_rem[ChW-1:0];
          state_d     = S_CCH;
          div_start_d = 1'b1;
        end
      end
      S_CCH: begin
        if (div_done) begin
          r2_d        = div_rem[ChW-1:0];
          state_d     = S_STEP;
          div_start_d = 1'b1;
        end
      end
      S_STEP: begin
        if (div_done) begin
          step_d      = div_rem[LenW-1:0];
          state_d     = S_PMOD;
          div_start_d = 1'b1;
        end
      end
      S_PMOD: begin
        if (div_done) begin
          if (pos_full > PosW'(nm_q)) begin
            pos_d = step_back(div_rem[LenW-1:0], step_q, len_q);
          end else begin
            pos_d = div_rem[LenW-1:0];
          end
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        rd_vld_d = 1'b1;
        pos_d    = step_back(pos_q, step_q, len_q);
        cnt_d    = cnt_q + WinW'(1);
        if (cnt_q == win_q - WinW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d     = S_AVG;
        div_start_d = 1'b1;
      end
      S_AVG: begin
        if (div_done) begin
          res_d   = div_quot[SAMPLE_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_avg_d   = res_q;
          out_chan_d  = chan_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      rd_vld_q    <= rd_vld_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q     <= chan_d;
    newest_q   <= newest_d;
    nm_q       <= nm_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    step_q     <= step_d;
    pos_q      <= pos_d;
    sum_q      <= sum_d;
    res_q      <= res_d;
    out_avg_q  <= out_avg_d;
    out_chan_q <= out_chan_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.average      = out_avg_q;
  assign out_o.channel_echo = out_chan_q;

  // Writes happen only in idle and reads only during the walk, so the two never meet.
  iarca_ram #(
    .Width (SAMPLE_W),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_eff[AddrW-1:0]),
    .wdata_i (in_i.sample),
    .raddr_i (pos_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  iarca_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  a_read_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_WALK || state_q == S_DRAIN))
    else $error("ring read data pending outside the walk");

  a_walk_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (pos_q < len_q && cnt_q < win_q))
    else $error("walk slot or count out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the done state");

endmodule
